// File: sv/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types, operation codes and constants of the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int FRAC_BITS = 8;

  localparam logic [3:0] OP_ADD   = 4'd0;
  localparam logic [3:0] OP_SUB   = 4'd1;
  localparam logic [3:0] OP_MUL   = 4'd2;
  localparam logic [3:0] OP_DIV   = 4'd3;
  localparam logic [3:0] OP_EQ    = 4'd4;
  localparam logic [3:0] OP_NE    = 4'd5;
  localparam logic [3:0] OP_GT    = 4'd6;
  localparam logic [3:0] OP_LT    = 4'd7;
  localparam logic [3:0] OP_GE    = 4'd8;
  localparam logic [3:0] OP_LE    = 4'd9;
  localparam logic [3:0] OP_MIN   = 4'd10;
  localparam logic [3:0] OP_MAX   = 4'd11;
  localparam logic [3:0] OP_INC   = 4'd12;
  localparam logic [3:0] OP_DEC   = 4'd13;
  localparam logic [3:0] OP_TOINT = 4'd14;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;

  // work class chosen by the front end
  localparam logic [1:0] K_DONE = 2'd0;
  localparam logic [1:0] K_MUL  = 2'd1;
  localparam logic [1:0] K_DIV  = 2'd2;

  localparam logic [31:0] MAX_S32 = 32'h7fff_ffff;
  localparam logic [31:0] MIN_S32 = 32'h8000_0000;

  localparam int QUO_W     = 33;             // quotient bits of 2n/d before rounding
  localparam int DIV_STEPS = QUO_W;
  localparam int NSTAGES   = DIV_STEPS + 3;  // prep, divide steps, round, sign
  localparam int FIFO_DEPTH = 2;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic [31:0]        res;
    logic               cmp;
    logic [1:0]         status;
  } fpa_item_t;

endpackage

// File: sv/fpa_in_if.sv
// ----------------------------------------------------------------------------
// fpa_in_if
// Operation channel: valid/ready with operation code and two operands.
// ----------------------------------------------------------------------------
interface fpa_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         operation;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;

  modport source (output valid, operation, operand_a, operand_b, input ready);
  modport sink   (input valid, operation, operand_a, operand_b, output ready);
endinterface

// File: sv/fpa_out_if.sv
// ----------------------------------------------------------------------------
// fpa_out_if
// Result channel: valid/ready with result value, compare flag and status.
// ----------------------------------------------------------------------------
interface fpa_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic               compare_true;
  logic [1:0]         status;

  modport source (output valid, result_value, compare_true, status, input ready);
  modport sink   (input valid, result_value, compare_true, status, output ready);
endinterface

// File: sv/fpa_front.sv
// ----------------------------------------------------------------------------
// fpa_front
// Takes operations, finishes the single-cycle ones and tags mul/div for the
// back end.
// ----------------------------------------------------------------------------
module fpa_front
  import fpa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  fpa_in_if.sink    in_ch,
  input  logic      q_full,
  output logic      q_push,
  output fpa_item_t q_item
);

  logic      vld_r, vld_nxt;
  fpa_item_t item_r, item_nxt;

  logic signed [31:0] a, b;
  logic [32:0]        sum, dif;

  function automatic logic [32:0] sat33(input logic [32:0] x);
    // returns {sat, value}
    if (x[32] != x[31]) begin
      return {1'b1, (x[32] ? MIN_S32 : MAX_S32)};
    end
    return {1'b0, x[31:0]};
  endfunction

  assign a = in_ch.operand_a;
  assign b = in_ch.operand_b;

  always_comb begin
    item_nxt        = '0;
    item_nxt.kind   = K_DONE;
    item_nxt.a      = a;
    item_nxt.b      = b;
    sum = {a[31], a} + {b[31], b};
    dif = {a[31], a} - {b[31], b};
    unique case (in_ch.operation)
      OP_ADD: begin
        {item_nxt.status[0], item_nxt.res} = sat33(sum);
      end
      OP_SUB: begin
        {item_nxt.status[0], item_nxt.res} = sat33(dif);
      end
      OP_MUL: item_nxt.kind = K_MUL;
      OP_DIV: begin
        if (b == 32'sd0) begin
          item_nxt.status = ST_DIVZ;
          item_nxt.res    = (a > 32'sd0) ? MAX_S32 : ((a < 32'sd0) ? MIN_S32 : 32'd0);
        end else begin
          item_nxt.kind = K_DIV;
        end
      end
      OP_EQ:  item_nxt.cmp = (a == b);
      OP_NE:  item_nxt.cmp = (a != b);
      OP_GT:  item_nxt.cmp = (a > b);
      OP_LT:  item_nxt.cmp = (a < b);
      OP_GE:  item_nxt.cmp = (a >= b);
      OP_LE:  item_nxt.cmp = (a <= b);
      OP_MIN: item_nxt.res = (a > b) ? b : a;
      OP_MAX: item_nxt.res = (a > b) ? a : b;
      OP_INC: begin
        {item_nxt.status[0], item_nxt.res} = sat33({a[31], a} + 33'd1);
      end
      OP_DEC: begin
        {item_nxt.status[0], item_nxt.res} = sat33({a[31], a} - 33'd1);
      end
      OP_TOINT: item_nxt.res = a >>> FRAC_BITS;
      default: ;
    endcase
  end

  assign q_push      = vld_r && !q_full;
  assign in_ch.ready = !vld_r || !q_full;
  assign q_item      = item_r;

  always_comb begin
    vld_nxt = vld_r;
    if (in_ch.valid && in_ch.ready) begin
      vld_nxt = 1'b1;
    end else if (q_push) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r <= item_nxt;
    end
  end

endmodule

// File: sv/fpa_fifo.sv
// ----------------------------------------------------------------------------
// fpa_fifo
// Short queue between the front end and the execution pipeline.
// ----------------------------------------------------------------------------
module fpa_fifo
  import fpa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  fpa_item_t wr_item,
  output logic      full,
  input  logic      pop,
  output logic      empty,
  output fpa_item_t rd_item
);

  localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  fpa_item_t     mem [FIFO_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == CW'(FIFO_DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_item = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    cnt_nxt = cnt_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_item;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(FIFO_DEPTH))
    else $error("queue count out of range");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("pop from empty queue");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");

endmodule

// File: sv/fpa_back.sv
// ----------------------------------------------------------------------------
// fpa_back
// Execution pipeline: multiply with rounding, restoring divide one quotient
// bit per stage, saturation, and the result register.
// ----------------------------------------------------------------------------
module fpa_back
  import fpa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  fpa_item_t q_item,
  output logic      q_pop,
  fpa_out_if.source out_ch
);

  typedef struct packed {
    logic [1:0]  kind;
    logic        neg;
    logic        ovf;
    logic [31:0] res;
    logic        cmp;
    logic [1:0]  status;
    logic [31:0] rem;
    logic [32:0] quo;
    logic [31:0] dvs;
    logic [63:0] wide;
  } bk_stage_t;

  localparam logic [63:0] HALF = (64'd1 << FRAC_BITS) >> 1;

  bk_stage_t   st  [NSTAGES];
  logic        vld_r [NSTAGES];
  logic        en;
  logic        out_vld_r;
  logic [31:0] out_res_r;
  logic        out_cmp_r;
  logic [1:0]  out_st_r;

  function automatic logic [32:0] sat_sign(input logic [63:0] q, input logic neg);
    // returns {sat, value}
    if (!neg) begin
      if (q > 64'(MAX_S32)) return {1'b1, MAX_S32};
      return {1'b0, q[31:0]};
    end
    if (q > 64'(MIN_S32)) return {1'b1, MIN_S32};
    return {1'b0, (~q[31:0]) + 32'd1};
  endfunction

  assign en    = !out_vld_r || out_ch.ready;
  assign q_pop = en && !q_empty;

  // prep stage
  bk_stage_t          prep;
  logic [31:0]        mag_a, mag_b;
  logic [63:0]        n2;
  logic signed [63:0] prod;

  always_comb begin
    mag_a = q_item.a[31] ? (~q_item.a) + 32'd1 : q_item.a;
    mag_b = q_item.b[31] ? (~q_item.b) + 32'd1 : q_item.b;
    n2    = 64'(mag_a) << (FRAC_BITS + 1);
    prod  = q_item.a * q_item.b;
    prep        = '0;
    prep.kind   = q_item.kind;
    prep.res    = q_item.res;
    prep.cmp    = q_item.cmp;
    prep.status = q_item.status;
    prep.neg    = q_item.a[31] ^ q_item.b[31];
    prep.ovf    = ({1'b0, n2[63:33]} >= mag_b);
    prep.rem    = {1'b0, n2[63:33]};
    prep.dvs    = mag_b;
    prep.wide   = (q_item.kind == K_MUL) ? prod : {31'd0, n2[32:0]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= prep;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= !q_empty;
    end
  end

  for (genvar k = 1; k < NSTAGES; k++) begin : g_st
    bk_stage_t   cur, nx;
    logic [32:0] t;
    logic [32:0] ss;

    assign cur = st[k-1];

    always_comb begin
      nx = cur;
      t  = {cur.rem, cur.wide[32]};
      ss = '0;
      // one quotient bit of the restoring divide
      if (k <= DIV_STEPS && cur.kind == K_DIV) begin
        if (t >= {1'b0, cur.dvs}) begin
          nx.rem = 32'(t - {1'b0, cur.dvs});
          nx.quo = {cur.quo[31:0], 1'b1};
        end else begin
          nx.rem = t[31:0];
          nx.quo = {cur.quo[31:0], 1'b0};
        end
        nx.wide = {cur.wide[62:0], 1'b0};
      end
      if (cur.kind == K_MUL) begin
        if (k == 1) begin
          nx.neg  = cur.wide[63];
          nx.wide = cur.wide[63] ? (~cur.wide) + 64'd1 : cur.wide;
        end else if (k == 2) begin
          nx.wide = (cur.wide + HALF) >> FRAC_BITS;
        end else if (k == 3) begin
          ss        = sat_sign(cur.wide, cur.neg);
          nx.res    = ss[31:0];
          nx.status = ss[32] ? ST_SAT : ST_OK;
        end
      end
      if (cur.kind == K_DIV) begin
        // rounding half away from zero: q = (floor(2n/d) + 1) / 2
        if (k == DIV_STEPS + 1 && !cur.ovf) begin
          nx.quo = 33'((34'(cur.quo) + 34'd1) >> 1);
        end else if (k == DIV_STEPS + 2) begin
          if (cur.ovf) begin
            nx.res    = cur.neg ? MIN_S32 : MAX_S32;
            nx.status = ST_SAT;
          end else begin
            ss        = sat_sign(64'(cur.quo), cur.neg);
            nx.res    = ss[31:0];
            nx.status = ss[32] ? ST_SAT : ST_OK;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[k] <= nx;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= vld_r[NSTAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_res_r <= st[NSTAGES-1].res;
      out_cmp_r <= st[NSTAGES-1].cmp;
      out_st_r  <= st[NSTAGES-1].status;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.result_value = out_res_r;
  assign out_ch.compare_true = out_cmp_r;
  assign out_ch.status       = out_st_r;

  a_cmp_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_cmp_r) |-> (out_res_r == 32'd0 && out_st_r == ST_OK))
    else $error("compare result with nonzero value or status");

  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_st_r == ST_SAT) |-> (out_res_r == MAX_S32 || out_res_r == MIN_S32))
    else $error("saturated result not at a bound");

  a_divz_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_st_r == ST_DIVZ) |-> !out_cmp_r)
    else $error("divide by zero with compare flag set");

endmodule

// File: sv/fixed_point_alu.sv
// ----------------------------------------------------------------------------
// fixed_point_alu
// Signed fixed-point ALU on raw 32-bit values, FRAC_BITS fractional bits.
// ----------------------------------------------------------------------------
// path from input transfer to result valid: front register, queue, prep, divide steps, round, sign, result register
// throughput: one operation per cycle while out_ch.ready does not stall, set by the 33-stage divide pipeline
// every operation walks the same pipeline, so results leave in input order
// reset: synchronous active-low rst_n empties front register, queue and pipeline
module fixed_point_alu
  import fpa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  fpa_in_if.sink    in_ch,
  fpa_out_if.source out_ch
);

  logic      q_full, q_push, q_pop, q_empty;
  fpa_item_t q_wr_item, q_rd_item;

  fpa_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_item (q_wr_item)
  );

  fpa_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_item (q_wr_item),
    .full    (q_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_item (q_rd_item)
  );

  fpa_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_item  (q_rd_item),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

// File: verif/fpa_tb_if.sv
// ----------------------------------------------------------------------------
// fpa_tb_if
// Interface instances used by the testbench come from the RTL files; this file
// holds only the operation record that the stimulus queue carries and the result record.
// ----------------------------------------------------------------------------
package fpa_tb_pkg;
  typedef struct {
    logic [3:0]         operation;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } alu_op_t;

  typedef struct {
    logic signed [31:0] result_value;
    logic               compare_true;
    logic [1:0]         status;
  } alu_res_t;
endpackage

// File: verif/tb_fixed_point_alu.sv
// ----------------------------------------------------------------------------
// tb_fixed_point_alu
// Drives directed and random operations into the fixed-point ALU with random
// idling on both sides, predicts every result in 64-bit arithmetic and
// compares the results in order, field by field.
// ----------------------------------------------------------------------------
module tb_fixed_point_alu;
  timeunit 1ns;
  timeprecision 1ps;
  import fpa_pkg::*;
  import fpa_tb_pkg::*;

  localparam int DRAIN_CYCLES = 80;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  fpa_in_if  in_ch();
  fpa_out_if out_ch();

  fixed_point_alu dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  alu_op_t  op_queue[$];
  alu_res_t expected_q[$];
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  bit       send_hold = 1'b0;
  int       mismatches = 0;
  bit       stim_done = 1'b0;

  function automatic longint sat32(longint v, ref logic [1:0] st);
    if (v > 64'sd2147483647) begin
      st = ST_SAT;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      st = ST_SAT;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // exact fixed-point math, rounding half away from zero
  function automatic alu_res_t compute_alu(alu_op_t op);
    alu_res_t r;
    longint a, b, v, p;
    logic [63:0] m, n, d, q;
    logic [1:0] st;
    a = op.operand_a;
    b = op.operand_b;
    v = 0;
    st = ST_OK;
    r.compare_true = 1'b0;
    case (op.operation)
      OP_ADD: v = sat32(a + b, st);
      OP_SUB: v = sat32(a - b, st);
      OP_MUL: begin
        p = a * b;
        m = (p < 0) ? -p : p;
        q = (m + ((64'd1 << FRAC_BITS) >> 1)) >> FRAC_BITS;
        v = sat32((p < 0) ? -longint'(q) : longint'(q), st);
      end
      OP_DIV: begin
        if (b == 0) begin
          st = ST_DIVZ;
          v = (a > 0) ? 64'sd2147483647 : ((a < 0) ? -64'sd2147483648 : 0);
        end else begin
          n = ((a < 0) ? -a : a) << FRAC_BITS;
          d = (b < 0) ? -b : b;
          q = (2 * n + d) / (2 * d);
          v = sat32(((a < 0) != (b < 0)) ? -longint'(q) : longint'(q), st);
        end
      end
      OP_EQ: r.compare_true = (a == b);
      OP_NE: r.compare_true = (a != b);
      OP_GT: r.compare_true = (a > b);
      OP_LT: r.compare_true = (a < b);
      OP_GE: r.compare_true = (a >= b);
      OP_LE: r.compare_true = (a <= b);
      OP_MIN: v = (a > b) ? b : a;
      OP_MAX: v = (a > b) ? a : b;
      OP_INC: v = sat32(a + 1, st);
      OP_DEC: v = sat32(a - 1, st);
      OP_TOINT: v = a >>> FRAC_BITS;
      default: v = 0;
    endcase
    r.result_value = v[31:0];
    r.status = st;
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.operation <= OP_ADD;
      in_ch.operand_a <= '0;
      in_ch.operand_b <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_q.push_back(compute_alu('{in_ch.operation, in_ch.operand_a,
                                           in_ch.operand_b}));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (op_queue.size() > 0 && !send_hold &&
            $urandom_range(99) >= send_idle_pct) begin
          alu_op_t nx;
          nx = op_queue.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.operation <= nx.operation;
          in_ch.operand_a <= nx.operand_a;
          in_ch.operand_b <= nx.operand_b;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transfer %h",
                                         out_ch.result_value);
        end else begin
          alu_res_t e;
          e = expected_q.pop_front();
          if (e.result_value !== out_ch.result_value ||
              e.compare_true !== out_ch.compare_true || e.status !== out_ch.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp val %h cmp %b st %0d, got val %h cmp %b st %0d",
                       e.result_value, e.compare_true, e.status, out_ch.result_value,
                       out_ch.compare_true, out_ch.status);
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(5))
      0: return $urandom_range(600) - 300;
      1: return {{16{$urandom_range(1) == 1}}, 16'($urandom)};
      2: return $urandom_range(1) ? 32'h7fff_ffff - $urandom_range(3)
                                  : 32'h8000_0000 + $urandom_range(3);
      3: return {{20{$urandom_range(1) == 1}}, 12'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic add_op(logic [3:0] op, logic [31:0] a, logic [31:0] b);
    op_queue.push_back('{op, a, b});
  endtask

  task automatic run_phase(int count, int s_pct, int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < count; i++) begin
      logic [3:0] op;
      op = $urandom_range(15);
      add_op(op, rand_operand(), ($urandom_range(19) == 0) ? 32'd0 : rand_operand());
    end
    while (op_queue.size() > 0) @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    // directed corners
    add_op(OP_ADD, 32'h7fff_ffff, 32'd1);
    add_op(OP_SUB, 32'h8000_0000, 32'd1);
    add_op(OP_MUL, 32'h7fff_ffff, 32'h7fff_ffff);
    add_op(OP_MUL, 32'hffff_ff80, 32'd1);
    add_op(OP_MUL, 32'd128, 32'd1);
    add_op(OP_DIV, 32'd5, 32'd0);
    add_op(OP_DIV, 32'h8000_0000, 32'd0);
    add_op(OP_DIV, 32'd0, 32'd0);
    add_op(OP_DIV, 32'h8000_0000, 32'hffff_ffff);
    add_op(OP_DIV, 32'hffff_ffff, 32'd512);
    add_op(OP_EQ, 32'd7, 32'd7);
    add_op(OP_NE, 32'd7, 32'd7);
    add_op(OP_NE, 32'd7, 32'd8);
    add_op(OP_GT, 32'h7fff_ffff, 32'h8000_0000);
    add_op(OP_LT, 32'h7fff_ffff, 32'h8000_0000);
    add_op(OP_GE, 32'd3, 32'd3);
    add_op(OP_LE, 32'hffff_ffff, 32'd0);
    add_op(OP_MIN, 32'd9, 32'hffff_fff0);
    add_op(OP_MAX, 32'd9, 32'hffff_fff0);
    add_op(OP_INC, 32'h7fff_ffff, 32'hffff_ffff);
    add_op(OP_DEC, 32'h8000_0000, 32'hffff_ffff);
    add_op(OP_TOINT, 32'hffff_ff01, 32'd0);
    add_op(OP_TOINT, 32'h8000_0000, 32'd0);
    add_op(4'd15, 32'hffff_ffff, 32'hffff_ffff);
    while (op_queue.size() > 0) @(posedge clk);
    run_phase(500, 27, 72);
    // hold off until the pipeline has drained
    send_hold = 1'b1;
    while (expected_q.size() > 0 || in_ch.valid) @(posedge clk);
    send_hold = 1'b0;
    run_phase(500, 72, 27);
    run_phase(530, 0, 0);
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    @(posedge clk);
    while (in_ch.valid || expected_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("tb_fixed_point_alu: done, clean");
    else $display("tb_fixed_point_alu: done, errors");
    $finish;
  end

  initial begin
    #2ms;
    $display("tb_fixed_point_alu: done, errors");
    $finish;
  end

endmodule
